// ----- hdl/ceau_pkg.sv -----
// Shared types and constants of the effective-address unit.
// Depends on nothing; the decode, top-level and testbench files import it.
`timescale 1ns / 1ps

package ceau_pkg;

  // Addressing mode codes; codes above MODE_NONE behave like MODE_NONE.
  typedef enum logic [3:0] {
    MODE_DIRECT   = 4'd0,
    MODE_INHERENT = 4'd1,
    MODE_IMM_BYTE = 4'd2,
    MODE_IMM_WORD = 4'd3,
    MODE_REL_BYTE = 4'd4,
    MODE_REL_WORD = 4'd5,
    MODE_INDEXED  = 4'd6,
    MODE_EXTENDED = 4'd7,
    MODE_NONE     = 4'd8
  } mode_e;

  // Low nibble of an indexed postbyte with bit 7 set.
  typedef enum logic [3:0] {
    IDX_POST_INC1 = 4'h0,
    IDX_POST_INC2 = 4'h1,
    IDX_PRE_DEC1  = 4'h2,
    IDX_PRE_DEC2  = 4'h3,
    IDX_ZERO_OFS  = 4'h4,
    IDX_ACC_B     = 4'h5,
    IDX_ACC_A     = 4'h6,
    IDX_OFS8      = 4'h8,
    IDX_OFS16     = 4'h9,
    IDX_ACC_D     = 4'hB,
    IDX_PCR8      = 4'hC,
    IDX_PCR16     = 4'hD
  } idx_form_e;

  localparam logic [7:0]  PB_EXT_INDIRECT = 8'b1001_1111;
  localparam logic [15:0] OFS5_NEG_FILL   = 16'hFFE0;
  localparam logic [3:0]  CYC_INDIRECT    = 4'd3;

  typedef struct packed {
    logic [3:0]  req_type;
    logic [15:0] prog_counter;
    logic [7:0]  direct_page;
    logic [7:0]  stream_byte0;
    logic [7:0]  stream_byte1;
    logic [7:0]  stream_byte2;
    logic [7:0]  acc_a;
    logic [7:0]  acc_b;
    logic [15:0] reg_x;
    logic [15:0] reg_y;
    logic [15:0] reg_u;
    logic [15:0] reg_s;
  } ea_req_t;

  typedef struct packed {
    logic [15:0] eff_address;
    logic        indirect;
    logic        legal;
    logic [15:0] next_pc;
    logic [3:0]  extra_cycles;
    logic        index_write;
    logic [1:0]  index_sel;
    logic [15:0] index_value;
  } ea_res_t;

  function automatic logic [15:0] sext8(input logic [7:0] b);
    return {{8{b[7]}}, b};
  endfunction

endpackage

// ----- hdl/ceau_decode.sv -----
// Combinational address decode: one operand request in, one result out.
// Depends on ceau_pkg for the request and result types and the mode codes.
`timescale 1ns / 1ps

module ceau_decode (
  input  ceau_pkg::ea_req_t req_i,
  output ceau_pkg::ea_res_t res_o
);
  import ceau_pkg::*;

  logic [15:0] pc1, pc2, pc3;
  logic [15:0] w01, w12, base;
  logic [15:0] opa, opb;
  logic [15:0] delta, upd;
  logic [7:0]  pb;
  logic [1:0]  sel;
  logic [3:0]  ind_cyc;
  logic        ind_form;
  ea_res_t     r;

  assign pc1 = req_i.prog_counter + 16'd1;
  assign pc2 = req_i.prog_counter + 16'd2;
  assign pc3 = req_i.prog_counter + 16'd3;
  assign w01 = {req_i.stream_byte0, req_i.stream_byte1};
  assign w12 = {req_i.stream_byte1, req_i.stream_byte2};
  assign pb  = req_i.stream_byte0;
  assign sel = pb[6:5];
  assign ind_form = pb[4];
  assign ind_cyc  = ind_form ? CYC_INDIRECT : 4'd0;

  always_comb begin
    unique case (sel)
      2'd0:    base = req_i.reg_x;
      2'd1:    base = req_i.reg_y;
      2'd2:    base = req_i.reg_u;
      default: base = req_i.reg_s;
    endcase
  end

  // Auto increment and decrement step; the write-back value is base plus it.
  always_comb begin
    case ({pb[1], pb[0]})
      2'b00:   delta = 16'd1;
      2'b01:   delta = 16'd2;
      2'b10:   delta = 16'hFFFF;
      default: delta = 16'hFFFE;
    endcase
  end
  assign upd = base + delta;

  always_comb begin
    r   = '0;
    opa = '0;
    opb = '0;
    r.next_pc = req_i.prog_counter;
    unique case (req_i.req_type)
      MODE_DIRECT: begin
        opa = {req_i.direct_page, req_i.stream_byte0};
        r.next_pc = pc1;
        r.legal = 1'b1;
      end
      MODE_INHERENT: r.legal = 1'b1;
      MODE_IMM_BYTE: begin
        opa = req_i.prog_counter;
        r.next_pc = pc1;
        r.legal = 1'b1;
      end
      MODE_IMM_WORD: begin
        opa = req_i.prog_counter;
        r.next_pc = pc2;
        r.legal = 1'b1;
      end
      MODE_REL_BYTE: begin
        opa = pc1;
        opb = sext8(req_i.stream_byte0);
        r.next_pc = pc1;
        r.legal = 1'b1;
      end
      MODE_REL_WORD: begin
        opa = pc2;
        opb = w01;
        r.next_pc = pc2;
        r.legal = 1'b1;
      end
      MODE_EXTENDED: begin
        opa = w01;
        r.next_pc = pc2;
        r.legal = 1'b1;
      end
      MODE_INDEXED: begin
        r.next_pc = pc1;
        r.legal = 1'b1;
        if (pb == PB_EXT_INDIRECT) begin
          opa = w12;
          r.next_pc = pc3;
          r.indirect = 1'b1;
          r.extra_cycles = 4'd5;
        end else if (!pb[7]) begin
          // Five-bit signed offset held in the postbyte itself.
          opa = base;
          opb = pb[4] ? (OFS5_NEG_FILL | {11'd0, pb[4:0]}) : {12'd0, pb[3:0]};
          r.extra_cycles = 4'd1;
        end else begin
          r.indirect = ind_form;
          case (pb[3:0])
            IDX_ZERO_OFS: begin
              opa = base;
              r.extra_cycles = ind_cyc;
            end
            IDX_OFS8: begin
              opa = base;
              opb = sext8(req_i.stream_byte1);
              r.next_pc = pc2;
              r.extra_cycles = 4'd1 + ind_cyc;
            end
            IDX_OFS16: begin
              opa = base;
              opb = w12;
              r.next_pc = pc3;
              r.extra_cycles = 4'd4 + ind_cyc;
            end
            IDX_ACC_A: begin
              opa = base;
              opb = sext8(req_i.acc_a);
              r.extra_cycles = 4'd1 + ind_cyc;
            end
            IDX_ACC_B: begin
              opa = base;
              opb = sext8(req_i.acc_b);
              r.extra_cycles = 4'd1 + ind_cyc;
            end
            IDX_ACC_D: begin
              opa = base;
              opb = {req_i.acc_a, req_i.acc_b};
              r.extra_cycles = 4'd4 + ind_cyc;
            end
            IDX_PCR8: begin
              opa = pc2;
              opb = sext8(req_i.stream_byte1);
              r.next_pc = pc2;
              r.extra_cycles = 4'd1 + ind_cyc;
            end
            IDX_PCR16: begin
              opa = pc3;
              opb = w12;
              r.next_pc = pc3;
              r.extra_cycles = 4'd5 + ind_cyc;
            end
            IDX_POST_INC1, IDX_PRE_DEC1: begin
              // Single-step forms have no indirect variant.
              if (ind_form) begin
                r.legal = 1'b0;
              end else begin
                opa = pb[1] ? upd : base;
                r.index_write = 1'b1;
                r.index_sel = sel;
                r.index_value = upd;
                r.extra_cycles = 4'd2;
              end
            end
            IDX_POST_INC2, IDX_PRE_DEC2: begin
              opa = pb[1] ? upd : base;
              r.index_write = 1'b1;
              r.index_sel = sel;
              r.index_value = upd;
              r.extra_cycles = 4'd3 + ind_cyc;
            end
            default: r.legal = 1'b0;
          endcase
        end
      end
      default: r.legal = 1'b0;
    endcase
    // Every address is formed by the one shared adder from opa and opb.
    r.eff_address = opa + opb;
    if (!r.legal) begin
      r.eff_address  = '0;
      r.indirect     = 1'b0;
      r.extra_cycles = '0;
      r.index_write  = 1'b0;
    end
    if (!r.index_write) begin
      r.index_sel   = '0;
      r.index_value = '0;
    end
    res_o = r;
  end

endmodule

// ----- hdl/cpu_effective_address_unit.sv -----
// Effective-address unit: input register, address decode, result register.
// An accepted input word is decoded from the input register; its result is held in the result register.
// Throughput: one word per cycle while the output is not stalled; while a result waits, a new word still
// enters as long as the input register is empty.
// Reset (rst_ni low, asynchronous) empties both registers; payload is kept.
// Depends on ceau_pkg and ceau_decode.
`timescale 1ns / 1ps

module cpu_effective_address_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // req_type [3:0]
  input  logic [3:0]   s_axis_tuser,
  // prog_counter, direct_page, stream_byte0, stream_byte1, stream_byte2,
  // acc_a, acc_b, reg_x, reg_y, reg_u, reg_s (lowest bit first)
  input  logic [127:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // indirect [0], legal [1]
  output logic [1:0]   m_axis_tuser,
  // eff_address [15:0], next_pc [31:16], extra_cycles [35:32],
  // index_write [36], index_sel [38:37], index_value [54:39], zero pad [55]
  output logic [55:0]  m_axis_tdata
);
  import ceau_pkg::*;

  logic    in_valid_q, in_valid_d;
  logic    out_valid_q, out_valid_d;
  logic    in_ready, out_ready;
  ea_req_t req_q, req_d;
  ea_res_t res_q, res_d;

  assign out_ready = !out_valid_q || m_axis_tready;
  assign in_ready  = !in_valid_q || out_ready;

  always_comb begin
    req_d.req_type     = s_axis_tuser;
    req_d.prog_counter = s_axis_tdata[15:0];
    req_d.direct_page  = s_axis_tdata[23:16];
    req_d.stream_byte0 = s_axis_tdata[31:24];
    req_d.stream_byte1 = s_axis_tdata[39:32];
    req_d.stream_byte2 = s_axis_tdata[47:40];
    req_d.acc_a        = s_axis_tdata[55:48];
    req_d.acc_b        = s_axis_tdata[63:56];
    req_d.reg_x        = s_axis_tdata[79:64];
    req_d.reg_y        = s_axis_tdata[95:80];
    req_d.reg_u        = s_axis_tdata[111:96];
    req_d.reg_s        = s_axis_tdata[127:112];
  end

  ceau_decode u_decode (
    .req_i(req_q),
    .res_o(res_d)
  );

  assign in_valid_d  = in_ready ? s_axis_tvalid : in_valid_q;
  assign out_valid_d = out_ready ? in_valid_q : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && s_axis_tvalid) begin
      req_q <= req_d;
    end
    if (out_ready && in_valid_q) begin
      res_q <= res_d;
    end
  end

  assign s_axis_tready = in_ready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = {res_q.legal, res_q.indirect};
  assign m_axis_tdata  = {1'b0, res_q.index_value, res_q.index_sel, res_q.index_write,
                          res_q.extra_cycles, res_q.next_pc, res_q.eff_address};

endmodule

// ----- hdl/ceau_checker.sv -----
// Port-level checks for the effective-address unit, bound to its top level.
// Depends on cpu_effective_address_unit's port list only.
`timescale 1ns / 1ps

module ceau_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         m_axis_tvalid_i,
  input logic         m_axis_tready_i,
  input logic [1:0]   m_axis_tuser_i,
  input logic [55:0]  m_axis_tdata_i
);

  // A result waiting on the output keeps its value until taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i && !m_axis_tready_i |=>
      m_axis_tvalid_i && $stable(m_axis_tdata_i) && $stable(m_axis_tuser_i))
    else $error("result word changed while stalled");

  // An illegal operand reports no address, no cycles and no write-back.
  a_illegal_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i && !m_axis_tuser_i[1] |->
      m_axis_tdata_i[15:0] == 16'd0 && m_axis_tdata_i[35:32] == 4'd0 &&
      !m_axis_tdata_i[36] && !m_axis_tuser_i[0])
    else $error("illegal result carries address, cycles or write-back");

  // Without a write-back the register select and value read as zero.
  a_no_wb_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i && !m_axis_tdata_i[36] |->
      m_axis_tdata_i[54:37] == 18'd0)
    else $error("write-back fields set without write-back");

  // Cycle count never exceeds the longest indexed form.
  a_cycles_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i |-> m_axis_tdata_i[35:32] <= 4'd8 && !m_axis_tdata_i[55])
    else $error("extra cycle count out of range");

endmodule

bind cpu_effective_address_unit ceau_checker u_ceau_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .m_axis_tvalid_i(m_axis_tvalid),
  .m_axis_tready_i(m_axis_tready),
  .m_axis_tuser_i (m_axis_tuser),
  .m_axis_tdata_i (m_axis_tdata)
);

// ----- tb/sv/cpu_effective_address_unit_test.sv -----
// Testbench for the effective-address unit: stream driver, result checker and
// a behavioral predictor of every addressing mode.
// Depends on ceau_pkg and the cpu_effective_address_unit RTL.
`timescale 1ns / 1ps

module cpu_effective_address_unit_test;
  import ceau_pkg::*;

  logic         clk_i          = 1'b0;
  logic         rst_ni         = 1'b0;
  logic         s_axis_tvalid  = 1'b0;
  logic         s_axis_tready;
  logic [3:0]   s_axis_tuser   = '0;
  logic [127:0] s_axis_tdata   = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready  = 1'b0;
  logic [1:0]   m_axis_tuser;
  logic [55:0]  m_axis_tdata;

  ea_res_t expected_addresses[$];
  int      send_gap_pct   = 0;
  int      recv_stall_pct = 0;
  int      mismatches     = 0;
  int      words_sent     = 0;
  int      words_checked  = 0;
  int      legal_seen     = 0;
  int      indirect_seen  = 0;
  int      writeback_seen = 0;

  cpu_effective_address_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic logic [15:0] signed_byte(input logic [7:0] b);
    return {{8{b[7]}}, b};
  endfunction

  function automatic ea_res_t compute_effective_address(input ea_req_t rq);
    ea_res_t     r;
    logic [15:0] pc;
    logic [15:0] base;
    logic [15:0] w01;
    logic [15:0] w12;
    logic [7:0]  pb;
    logic        ind;
    logic [3:0]  ind_cycles;
    r   = '0;
    pc  = rq.prog_counter;
    w01 = {rq.stream_byte0, rq.stream_byte1};
    w12 = {rq.stream_byte1, rq.stream_byte2};
    r.next_pc = pc;
    case (rq.req_type)
      MODE_DIRECT: begin
        r.eff_address = {rq.direct_page, rq.stream_byte0};
        r.next_pc     = pc + 16'd1;
        r.legal       = 1'b1;
      end
      MODE_INHERENT: r.legal = 1'b1;
      MODE_IMM_BYTE: begin
        r.eff_address = pc;
        r.next_pc     = pc + 16'd1;
        r.legal       = 1'b1;
      end
      MODE_IMM_WORD: begin
        r.eff_address = pc;
        r.next_pc     = pc + 16'd2;
        r.legal       = 1'b1;
      end
      MODE_REL_BYTE: begin
        r.next_pc     = pc + 16'd1;
        r.eff_address = r.next_pc + signed_byte(rq.stream_byte0);
        r.legal       = 1'b1;
      end
      MODE_REL_WORD: begin
        r.next_pc     = pc + 16'd2;
        r.eff_address = r.next_pc + w01;
        r.legal       = 1'b1;
      end
      MODE_EXTENDED: begin
        r.eff_address = w01;
        r.next_pc     = pc + 16'd2;
        r.legal       = 1'b1;
      end
      MODE_INDEXED: begin
        pb = rq.stream_byte0;
        case (pb[6:5])
          2'd0: base = rq.reg_x;
          2'd1: base = rq.reg_y;
          2'd2: base = rq.reg_u;
          default: base = rq.reg_s;
        endcase
        ind        = pb[4];
        ind_cycles = ind ? CYC_INDIRECT : 4'd0;
        r.next_pc  = pc + 16'd1;
        r.legal    = 1'b1;
        if (pb == PB_EXT_INDIRECT) begin
          r.eff_address  = w12;
          r.next_pc      = pc + 16'd3;
          r.indirect     = 1'b1;
          r.extra_cycles = 4'd5;
        end else if (!pb[7]) begin
          // Five-bit signed offset; bit 4 is the sign, not the indirect flag.
          r.eff_address  = base + (pb[4] ? (OFS5_NEG_FILL | {11'd0, pb[4:0]})
                                         : {12'd0, pb[3:0]});
          r.extra_cycles = 4'd1;
        end else begin
          r.indirect = ind;
          case (pb[3:0])
            IDX_ZERO_OFS: begin
              r.eff_address  = base;
              r.extra_cycles = ind_cycles;
            end
            IDX_OFS8: begin
              r.eff_address  = base + signed_byte(rq.stream_byte1);
              r.next_pc      = pc + 16'd2;
              r.extra_cycles = 4'd1 + ind_cycles;
            end
            IDX_OFS16: begin
              r.eff_address  = base + w12;
              r.next_pc      = pc + 16'd3;
              r.extra_cycles = 4'd4 + ind_cycles;
            end
            IDX_ACC_A: begin
              r.eff_address  = base + signed_byte(rq.acc_a);
              r.extra_cycles = 4'd1 + ind_cycles;
            end
            IDX_ACC_B: begin
              r.eff_address  = base + signed_byte(rq.acc_b);
              r.extra_cycles = 4'd1 + ind_cycles;
            end
            IDX_ACC_D: begin
              r.eff_address  = base + {rq.acc_a, rq.acc_b};
              r.extra_cycles = 4'd4 + ind_cycles;
            end
            IDX_PCR8: begin
              r.eff_address  = pc + 16'd2 + signed_byte(rq.stream_byte1);
              r.next_pc      = pc + 16'd2;
              r.extra_cycles = 4'd1 + ind_cycles;
            end
            IDX_PCR16: begin
              r.eff_address  = pc + 16'd3 + w12;
              r.next_pc      = pc + 16'd3;
              r.extra_cycles = 4'd5 + ind_cycles;
            end
            IDX_POST_INC1, IDX_PRE_DEC1: begin
              // Single-step auto forms have no indirect variant.
              if (ind) begin
                r.legal = 1'b0;
              end else begin
                r.index_write  = 1'b1;
                r.index_sel    = pb[6:5];
                r.extra_cycles = 4'd2;
                if (pb[1]) begin
                  r.index_value = base - 16'd1;
                  r.eff_address = r.index_value;
                end else begin
                  r.index_value = base + 16'd1;
                  r.eff_address = base;
                end
              end
            end
            IDX_POST_INC2, IDX_PRE_DEC2: begin
              r.index_write  = 1'b1;
              r.index_sel    = pb[6:5];
              r.extra_cycles = 4'd3 + ind_cycles;
              if (pb[1]) begin
                r.index_value = base - 16'd2;
                r.eff_address = r.index_value;
              end else begin
                r.index_value = base + 16'd2;
                r.eff_address = base;
              end
            end
            default: r.legal = 1'b0;
          endcase
        end
      end
      default: ;
    endcase
    if (!r.legal) begin
      r.eff_address  = '0;
      r.indirect     = 1'b0;
      r.extra_cycles = '0;
      r.index_write  = 1'b0;
    end
    if (!r.index_write) begin
      r.index_sel   = '0;
      r.index_value = '0;
    end
    return r;
  endfunction

  function automatic logic [15:0] random_word();
    case ($urandom_range(7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'hFFFE;
      3: return 16'h0001;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic ea_req_t random_request(input logic [3:0] mode);
    ea_req_t rq;
    rq.req_type     = mode;
    rq.prog_counter = random_word();
    rq.direct_page  = 8'($urandom);
    rq.stream_byte0 = 8'($urandom);
    rq.stream_byte1 = 8'($urandom);
    rq.stream_byte2 = 8'($urandom);
    rq.acc_a        = 8'($urandom);
    rq.acc_b        = 8'($urandom);
    rq.reg_x        = random_word();
    rq.reg_y        = random_word();
    rq.reg_u        = random_word();
    rq.reg_s        = random_word();
    return rq;
  endfunction

  // Leaves tvalid high after acceptance; the next call replaces the word or lowers it for a gap, a drain lowers it.
  task automatic send_request(input ea_req_t rq);
    while ($urandom_range(99) < send_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= rq.req_type;
    s_axis_tdata  <= {rq.reg_s, rq.reg_u, rq.reg_y, rq.reg_x, rq.acc_b, rq.acc_a,
                      rq.stream_byte2, rq.stream_byte1, rq.stream_byte0,
                      rq.direct_page, rq.prog_counter};
    do @(posedge clk_i); while (!s_axis_tready);
    expected_addresses.push_back(compute_effective_address(rq));
    words_sent++;
    @(negedge clk_i);
  endtask

  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    while (expected_addresses.size() != 0) @(negedge clk_i);
  endtask

  function automatic void compare_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    ea_res_t want;
    ea_res_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.eff_address  = m_axis_tdata[15:0];
      got.next_pc      = m_axis_tdata[31:16];
      got.extra_cycles = m_axis_tdata[35:32];
      got.index_write  = m_axis_tdata[36];
      got.index_sel    = m_axis_tdata[38:37];
      got.index_value  = m_axis_tdata[54:39];
      got.indirect     = m_axis_tuser[0];
      got.legal        = m_axis_tuser[1];
      if (expected_addresses.size() == 0) begin
        $display("%0t ns: unexpected result word, expected none, actual 0x%0h",
                 $time, got);
        mismatches++;
      end else begin
        want = expected_addresses.pop_front();
        compare_field("eff_address", want.eff_address, got.eff_address);
        compare_field("indirect", 16'(want.indirect), 16'(got.indirect));
        compare_field("legal", 16'(want.legal), 16'(got.legal));
        compare_field("next_pc", want.next_pc, got.next_pc);
        compare_field("extra_cycles", 16'(want.extra_cycles), 16'(got.extra_cycles));
        compare_field("index_write", 16'(want.index_write), 16'(got.index_write));
        compare_field("index_sel", 16'(want.index_sel), 16'(got.index_sel));
        compare_field("index_value", want.index_value, got.index_value);
        words_checked++;
        legal_seen     += got.legal;
        indirect_seen  += got.indirect;
        writeback_seen += got.index_write;
      end
    end
  end

  task automatic test_plain_modes();
    ea_req_t rq;
    rq = random_request(MODE_DIRECT);
    rq.direct_page  = 8'hFF;
    rq.stream_byte0 = 8'hFF;
    send_request(rq);
    send_request(random_request(MODE_INHERENT));
    rq = random_request(MODE_IMM_BYTE);
    rq.prog_counter = 16'hFFFF;
    send_request(rq);
    rq = random_request(MODE_IMM_WORD);
    rq.prog_counter = 16'hFFFE;
    send_request(rq);
    rq = random_request(MODE_REL_BYTE);
    rq.prog_counter = 16'h0000;
    rq.stream_byte0 = 8'h80;
    send_request(rq);
    rq = random_request(MODE_REL_WORD);
    rq.prog_counter = 16'hFFFD;
    rq.stream_byte0 = 8'h7F;
    rq.stream_byte1 = 8'hFF;
    send_request(rq);
    rq = random_request(MODE_EXTENDED);
    rq.stream_byte0 = 8'hFF;
    rq.stream_byte1 = 8'h00;
    send_request(rq);
    send_request(random_request(MODE_NONE));
    // Unused mode codes must decode as no mode at all.
    send_request(random_request(4'hF));
  endtask

  task automatic test_indexed_forms();
    idx_form_e forms [12] = '{IDX_POST_INC1, IDX_POST_INC2, IDX_PRE_DEC1, IDX_PRE_DEC2,
                              IDX_ZERO_OFS, IDX_ACC_B, IDX_ACC_A, IDX_OFS8, IDX_OFS16,
                              IDX_ACC_D, IDX_PCR8, IDX_PCR16};
    ea_req_t   rq;
    logic      ind;
    for (int i = 0; i < 12; i++) begin
      rq  = random_request(MODE_INDEXED);
      ind = (forms[i] == IDX_POST_INC1 || forms[i] == IDX_PRE_DEC1) ? 1'b0 : 1'(i % 2);
      rq.stream_byte0 = {1'b1, 2'(i % 4), ind, forms[i]};
      rq.stream_byte1 = 8'h80;
      rq.stream_byte2 = 8'hFF;
      rq.acc_a        = 8'h80;
      rq.acc_b        = 8'h7F;
      rq.prog_counter = 16'hFFFE;
      {rq.reg_x, rq.reg_y, rq.reg_u, rq.reg_s} = (i % 3 == 0) ? '0 : '1;
      send_request(rq);
    end
    rq = random_request(MODE_INDEXED);
    rq.stream_byte0 = 8'h0F;
    send_request(rq);
    rq = random_request(MODE_INDEXED);
    rq.stream_byte0 = 8'h70;
    send_request(rq);
    rq = random_request(MODE_INDEXED);
    rq.stream_byte0 = PB_EXT_INDIRECT;
    rq.prog_counter = 16'hFFFE;
    send_request(rq);
  endtask

  task automatic test_illegal_postbytes();
    logic [7:0] bad [4] = '{8'h87, 8'hBA, 8'hF0, 8'hBF};
    ea_req_t    rq;
    foreach (bad[i]) begin
      rq = random_request(MODE_INDEXED);
      rq.stream_byte0 = bad[i];
      send_request(rq);
    end
  endtask

  task automatic test_random_traffic(input int count);
    ea_req_t rq;
    int      pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        rq = random_request(MODE_INDEXED);
        if ($urandom_range(15) == 0) rq.stream_byte0 = PB_EXT_INDIRECT;
      end else if (pick < 95) begin
        rq = random_request(4'($urandom_range(8)));
      end else begin
        rq = random_request(4'($urandom_range(15, 9)));
      end
      send_request(rq);
    end
  endtask

  initial begin
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    send_gap_pct   = 37;
    recv_stall_pct = 53;
    test_plain_modes();
    test_indexed_forms();
    test_illegal_postbytes();
    // Let the pipe run dry once before the random traffic starts.
    wait_for_results();
    test_random_traffic(700);
    send_gap_pct   = 53;
    recv_stall_pct = 37;
    test_random_traffic(700);
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    test_random_traffic(575);
    wait_for_results();
    repeat (8) @(negedge clk_i);
    $display("Sent %0d words, checked %0d results, %0d mismatches.",
             words_sent, words_checked, mismatches);
    $display("Results seen: %0d legal, %0d indirect, %0d with index write-back.",
             legal_seen, indirect_seen, writeback_seen);
    if (mismatches == 0 && expected_addresses.size() == 0) begin
      $display("cpu_effective_address_unit_test OK");
    end else begin
      $display("cpu_effective_address_unit_test NOT OK");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("%0t ns: timeout with %0d results outstanding", $time, expected_addresses.size());
    $display("cpu_effective_address_unit_test NOT OK");
    $finish;
  end

endmodule
